// File: hdl/wtd_pkg.sv
// ----------------------------------------------------------------------------
// Wheel telemetry deframer package
// Shared constants and the command and status types between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package wtd_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hAA;
    localparam logic [7:0] ERR_BYTE = 8'hFE;
    localparam logic [7:0] SUM_OK   = 8'hFF;

    localparam logic [2:0] LAST_INDEX = 3'd5;

    localparam logic [9:0]  SPEED_SCALE  = 10'd1000;
    localparam logic [20:0] PERIOD_LIMIT = 21'd30;

    localparam int DVD_W    = 26;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

    localparam int DATA_W = 96;

    localparam logic [1:0] STATUS_GOOD   = 2'd0;
    localparam logic [1:0] STATUS_CSUM   = 2'd1;
    localparam logic [1:0] STATUS_REMOTE = 2'd2;

    typedef struct packed {
        logic take_byte;
        logic mul;
        logic div_step;
        logic finish;
    } wtd_cmd_t;

    typedef struct packed {
        logic last_byte;
        logic compute_needed;
        logic div_last;
        logic out_valid;
    } wtd_stat_t;

endpackage

// File: hdl/wheel_telemetry_deframer_unit.sv
// ----------------------------------------------------------------------------
// Wheel telemetry deframer
// Cuts received serial bytes into six-byte frames and reports position,
// period, position change, distance and speed for each good frame but the first.
//
// Channel   Direction  Transaction
// s_axis    in         one received byte, tdata[7:0]
// m_axis    out        one frame result, tdata 96 bits, tuser status
// cfg       in         distance per tick in micrometres, 16 bits
//
// Bytes are taken while s_axis_tready is high; results come only at a frame end.
// A good frame after priming holds s_axis_tready low after its final byte
// through one product state, 26 restoring divider steps and one load state.
// The result register lets the next frame's first five bytes enter while a
// result waits; the final byte waits until that result is taken.
// Reset clears sync, the byte counter, priming, the held speed and the result.
// ----------------------------------------------------------------------------
module wheel_telemetry_deframer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] wheel_position, [31:16] wheel_period, [47:32] tick_delta,
    // [79:48] distance_um, [94:80] speed_mm_s, [95] motion_valid
    output logic [95:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    wtd_pkg::wtd_cmd_t  cmd;
    wtd_pkg::wtd_stat_t stat;

    wtd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wtd_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_byte     (s_axis_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser)
    );

endmodule

// File: hdl/wtd_ctrl.sv
// ----------------------------------------------------------------------------
// Wheel telemetry deframer controller
// Sequences byte intake, the product cycle, the divider and the result load.
// ----------------------------------------------------------------------------
module wtd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  wtd_pkg::wtd_stat_t stat,
    output wtd_pkg::wtd_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_RECV = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign s_tready = (state_reg == ST_RECV) && !(stat.last_byte && stat.out_valid);
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.take_byte = take;
        unique case (state_reg)
            ST_RECV:
            begin
                if (take && stat.compute_needed)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_RECV;
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && stat.div_last) |=> (state_reg == ST_DONE))
        else $error("divider did not hand over to the result load");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RECV) |-> !cmd.take_byte)
        else $error("byte taken while a frame is being computed");
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !stat.out_valid)
        else $error("result load would overwrite a pending result");
`endif

endmodule

// File: hdl/wtd_datapath.sv
// ----------------------------------------------------------------------------
// Wheel telemetry deframer datapath
// Framing state, checksum, frame store, products, restoring divider and the
// result register.
// ----------------------------------------------------------------------------
module wtd_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [15:0]                 cfg_wr_data,
    input  logic [7:0]                  rx_byte,
    input  wtd_pkg::wtd_cmd_t           cmd,
    output wtd_pkg::wtd_stat_t          stat,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [wtd_pkg::DATA_W-1:0]  m_tdata,
    output logic [1:0]                  m_tuser
);

    logic [15:0] dist_reg;
    logic        synced_reg;
    logic [2:0]  idx_reg;
    logic [7:0]  sum_reg;
    logic        err_reg;
    logic [7:0]  fb_reg [4];
    logic [15:0] last_pos_reg;
    logic        primed_reg;
    logic [14:0] held_reg;

    logic [15:0] pos_reg;
    logic [15:0] per_reg;
    logic [15:0] delta_reg;
    logic [31:0] prod_reg;
    logic [wtd_pkg::DVD_W-1:0] dvd_reg;
    logic [15:0] rem_reg;
    logic [wtd_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic                       out_valid_reg;
    logic [1:0]                 out_status_reg;
    logic [wtd_pkg::DATA_W-1:0] out_data_reg;

    logic [7:0]  sum_fin;
    logic [2:0]  idx_m1;
    logic [15:0] frame_pos;
    logic [15:0] frame_per;
    logic        sum_good;
    logic [16:0] rem_sh;
    logic        rem_ge;
    logic        fast_ok;
    logic [14:0] speed_next;

    assign sum_fin   = sum_reg + rx_byte;
    assign idx_m1    = idx_reg - 3'd1;
    assign frame_pos = {fb_reg[1], fb_reg[0]};
    assign frame_per = {fb_reg[3], fb_reg[2]};
    assign sum_good  = (sum_fin == wtd_pkg::SUM_OK);

    assign stat.last_byte      = synced_reg && (idx_reg == wtd_pkg::LAST_INDEX);
    assign stat.compute_needed = stat.last_byte && !err_reg && sum_good && primed_reg;
    assign stat.div_last       = (cnt_reg == wtd_pkg::DIV_LAST);
    assign stat.out_valid      = out_valid_reg;

    assign rem_sh  = {rem_reg, dvd_reg[wtd_pkg::DVD_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, per_reg});
    assign fast_ok = ({5'd0, per_reg} * wtd_pkg::PERIOD_LIMIT) > {5'd0, dist_reg};

    always_comb
    begin
        if (delta_reg == 16'd0)
        begin
            speed_next = 15'd0;
        end
        else if (fast_ok)
        begin
            speed_next = dvd_reg[14:0];
        end
        else
        begin
            speed_next = held_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg       <= 16'd0;
            synced_reg     <= 1'b0;
            idx_reg        <= 3'd0;
            sum_reg        <= 8'd0;
            err_reg        <= 1'b0;
            last_pos_reg   <= 16'd0;
            primed_reg     <= 1'b0;
            held_reg       <= 15'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dist_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.take_byte)
            begin
                if (!synced_reg)
                begin
                    if (rx_byte == wtd_pkg::HDR_BYTE)
                    begin
                        synced_reg <= 1'b1;
                        idx_reg    <= 3'd1;
                        sum_reg    <= wtd_pkg::HDR_BYTE;
                        err_reg    <= 1'b0;
                    end
                end
                else if (idx_reg == 3'd0)
                begin
                    err_reg <= (rx_byte == wtd_pkg::ERR_BYTE);
                    sum_reg <= rx_byte;
                    idx_reg <= 3'd1;
                end
                else if (idx_reg != wtd_pkg::LAST_INDEX)
                begin
                    sum_reg <= sum_fin;
                    idx_reg <= idx_reg + 3'd1;
                end
                else
                begin
                    sum_reg <= sum_fin;
                    idx_reg <= 3'd0;
                    if (err_reg)
                    begin
                        err_reg       <= 1'b0;
                        synced_reg    <= 1'b0;
                        out_valid_reg <= 1'b1;
                    end
                    else if (!sum_good)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        primed_reg   <= 1'b1;
                        last_pos_reg <= frame_pos;
                    end
                end
            end
            if (cmd.finish)
            begin
                held_reg      <= speed_next;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && synced_reg && idx_reg != 3'd0 &&
            idx_reg != wtd_pkg::LAST_INDEX)
        begin
            fb_reg[idx_m1[1:0]] <= rx_byte;
        end
        if (cmd.take_byte && stat.last_byte)
        begin
            pos_reg   <= frame_pos;
            per_reg   <= frame_per;
            delta_reg <= last_pos_reg - frame_pos;
            if (err_reg)
            begin
                out_status_reg <= wtd_pkg::STATUS_REMOTE;
                out_data_reg   <= '0;
            end
            else if (!sum_good)
            begin
                out_status_reg <= wtd_pkg::STATUS_CSUM;
                out_data_reg   <= '0;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= delta_reg * dist_reg;
            dvd_reg  <= wtd_pkg::DVD_W'(dist_reg * wtd_pkg::SPEED_SCALE);
            rem_reg  <= 16'd0;
            cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= 16'(rem_sh - {1'b0, per_reg});
            end
            else
            begin
                rem_reg <= rem_sh[15:0];
            end
            dvd_reg <= {dvd_reg[wtd_pkg::DVD_W-2:0], rem_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            out_status_reg <= wtd_pkg::STATUS_GOOD;
            out_data_reg   <= {(dist_reg != 16'd0), speed_next, prod_reg,
                               delta_reg, per_reg, pos_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

// File: sim/tb_wheel_telemetry_deframer_unit.sv
// ----------------------------------------------------------------------------
// Wheel telemetry deframer testbench
// Streams serial bytes into the deframer and checks every frame result
// against a cycle-free predictor of the frame, checksum and speed logic.
// A short directed part is followed by four random phases that vary the
// distance per tick and the idle pattern on both stream channels.
// ----------------------------------------------------------------------------
module tb_wheel_telemetry_deframer_unit;

    localparam int HALF_PERIOD     = 10;
    localparam int SETTLE_CYCLES   = 40;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_BYTES     = 256;
    localparam int MAX_PRINTED     = 40;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] position;
        logic [15:0] period;
        logic [15:0] delta;
        logic [31:0] distance;
        logic [14:0] speed;
        logic        motion_valid;
    } frame_result_t;

    class telemetry_scoreboard;
        bit            synced        = 1'b0;
        logic [2:0]    byte_pos      = '0;
        bit            error_frame   = 1'b0;
        logic [7:0]    running_sum   = '0;
        logic [7:0]    payload [4];
        logic [15:0]   last_position = '0;
        bit            primed        = 1'b0;
        logic [14:0]   held_speed    = '0;
        logic [15:0]   um_per_tick   = '0;
        frame_result_t expected_frames [$];
        int            errors        = 0;
        int            good_frames   = 0;
        int            csum_frames   = 0;
        int            remote_frames = 0;

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void take_rx_byte(logic [7:0] rx);
            frame_result_t r;
            logic [15:0]   pos;
            logic [15:0]   per;
            logic [15:0]   delta;
            logic [31:0]   d;
            if (!synced)
            begin
                if (rx == wtd_pkg::HDR_BYTE)
                begin
                    synced      = 1'b1;
                    byte_pos    = 3'd1;
                    running_sum = wtd_pkg::HDR_BYTE;
                    error_frame = 1'b0;
                end
                return;
            end
            if (byte_pos == 3'd0)
            begin
                error_frame = (rx == wtd_pkg::ERR_BYTE);
                running_sum = rx;
                byte_pos    = 3'd1;
                return;
            end
            if (byte_pos < wtd_pkg::LAST_INDEX)
            begin
                payload[byte_pos - 3'd1] = rx;
                running_sum += rx;
                byte_pos++;
                return;
            end
            running_sum += rx;
            byte_pos = 3'd0;
            r = '{default: '0};
            if (error_frame)
            begin
                error_frame = 1'b0;
                synced      = 1'b0;
                r.status    = wtd_pkg::STATUS_REMOTE;
                remote_frames++;
                expected_frames.push_back(r);
                return;
            end
            if (running_sum != wtd_pkg::SUM_OK)
            begin
                r.status = wtd_pkg::STATUS_CSUM;
                csum_frames++;
                expected_frames.push_back(r);
                return;
            end
            pos = {payload[1], payload[0]};
            per = {payload[3], payload[2]};
            if (!primed)
            begin
                primed        = 1'b1;
                last_position = pos;
                return;
            end
            delta         = last_position - pos;
            last_position = pos;
            d             = {16'd0, um_per_tick};
            // A period too short for the configured travel keeps the old speed.
            if (delta == '0)
                held_speed = '0;
            else if ({16'd0, per} * 32'd30 > d)
                held_speed = 15'((d * 32'd1000) / {16'd0, per});
            r.status       = wtd_pkg::STATUS_GOOD;
            r.position     = pos;
            r.period       = per;
            r.delta        = delta;
            r.distance     = {16'd0, delta} * d;
            r.speed        = held_speed;
            r.motion_valid = (um_per_tick != '0);
            good_frames++;
            expected_frames.push_back(r);
        endfunction

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_frame_result(logic [95:0] data, logic [1:0] user);
            frame_result_t e;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("result with status %0d and no frame pending", user));
                return;
            end
            e = expected_frames.pop_front();
            compare_field("status", 32'(user), 32'(e.status));
            compare_field("wheel_position", 32'(data[15:0]), 32'(e.position));
            compare_field("wheel_period", 32'(data[31:16]), 32'(e.period));
            compare_field("tick_delta", 32'(data[47:32]), 32'(e.delta));
            compare_field("distance_um", data[79:48], e.distance);
            compare_field("speed_mm_s", 32'(data[94:80]), 32'(e.speed));
            compare_field("motion_valid", 32'(data[95]), 32'(e.motion_valid));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    telemetry_scoreboard sb;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int bytes_sent    = 0;
    int frame_bytes   = 0;
    logic [15:0] third_setting;
    logic [15:0] fourth_setting;

    wheel_telemetry_deframer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served  <= hold_requests;
            hold_left     <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_frame_result(m_axis_tdata, m_axis_tuser);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_wheel_telemetry_deframer_unit failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(logic [7:0] rx);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_rx_byte(rx);
        bytes_sent++;
    endtask

    task automatic send_frame(logic [7:0] lead, logic [15:0] pos, logic [15:0] per,
                              bit bad_sum);
        logic [7:0] sum;
        logic [7:0] tail;
        sum  = lead + pos[7:0] + pos[15:8] + per[7:0] + per[15:8];
        tail = wtd_pkg::SUM_OK - sum;
        if (bad_sum)
            tail = tail + 8'($urandom_range(1, 255));
        send_byte(lead);
        send_byte(pos[7:0]);
        send_byte(pos[15:8]);
        send_byte(per[7:0]);
        send_byte(per[15:8]);
        send_byte(tail);
        frame_bytes += 6;
    endtask

    // Mostly well-formed frames with small position steps, plus checksum
    // failures, remote errors and line noise while hunting for a header.
    task automatic send_random_frame();
        int          pick;
        logic [7:0]  lead;
        logic [7:0]  noise;
        logic [15:0] pos;
        logic [15:0] per;
        pick = $urandom_range(0, 99);
        if (!sb.synced)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    noise = 8'($urandom_range(0, 255));
                    if (noise == wtd_pkg::HDR_BYTE)
                        noise = wtd_pkg::ERR_BYTE;
                    send_byte(noise);
                end
            end
            lead = wtd_pkg::HDR_BYTE;
        end
        else if (pick < 8)
            lead = wtd_pkg::ERR_BYTE;
        else
            lead = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       pos = sb.last_position;
            1, 2:    pos = sb.last_position + 16'($urandom_range(0, 40)) - 16'd20;
            default: pos = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 3))
            0:       per = 16'($urandom_range(0, 50));
            1:       per = 16'($urandom_range(0, 3000));
            2:       per = 16'($urandom_range(1000, 65535));
            default: per = 16'($urandom_range(0, 65535));
        endcase
        send_frame(lead, pos, per, (pick >= 8) && (pick < 18));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_distance(logic [15:0] um);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= um;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.um_per_tick = um;
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, logic [15:0] um, bit hold_off);
        int start;
        settle();
        write_distance(um);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start       = frame_bytes;
        if (hold_off)
            hold_requests++;
        while (frame_bytes - start < PHASE_BYTES)
            send_random_frame();
    endtask

    initial
    begin
        sb = new;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_distance(16'd1000);
        // Noise while hunting, then a priming header frame, a wrapped step with
        // a zero period, a checksum failure and a remote error.
        send_byte(8'h00);
        send_byte(wtd_pkg::ERR_BYTE);
        send_frame(wtd_pkg::HDR_BYTE, 16'h0000, 16'hFFFF, 1'b0);
        send_frame(8'h00, 16'hFFFF, 16'h0000, 1'b0);
        send_frame(8'hFF, 16'hFF00, 16'h00FF, 1'b1);
        send_frame(wtd_pkg::ERR_BYTE, 16'h5A5A, 16'hA5A5, 1'b0);

        third_setting  = 16'($urandom_range(1, 3000));
        fourth_setting = 16'($urandom_range(0, 65535));
        run_phase(22, 68, 16'hFFFF, 1'b0);
        run_phase(68, 22, 16'h0000, 1'b0);
        run_phase(0, 0, third_setting, 1'b1);
        run_phase(0, 0, fourth_setting, 1'b0);
        settle();

        if (sb.expected_frames.size() != 0)
            sb.report($sformatf("%0d frame results never arrived",
                                sb.expected_frames.size()));
        $display("Streamed %0d bytes; checked %0d good, %0d checksum and %0d remote error frames.",
                 bytes_sent, sb.good_frames, sb.csum_frames, sb.remote_frames);
        $display("Distance per tick 1000, 65535, 0, %0d and %0d; one long output hold-off.",
                 third_setting, fourth_setting);
        if (sb.errors == 0)
            $display("tb_wheel_telemetry_deframer_unit passed");
        else
            $display("tb_wheel_telemetry_deframer_unit failed");
        $finish;
    end

endmodule
